### rtl/gbn_pkg.sv
// Shared types, widths, command and result codes for the Go-Back-N sender.
// Modular sequence helpers used by the sequencer. No dependencies.

package gbn_pkg;

   localparam int SEQ_SPACE_DEF = 8;
   localparam int SEQ_W         = 3;
   localparam int DATA_W        = 32;
   localparam int CMD_W         = 3;
   localparam int KIND_W        = 2;
   localparam int WIN_W         = 3;
   localparam int MOD_W         = 4;   // modulus runs up to 8

   localparam logic [WIN_W-1:0] WINDOW_RESET = 3'd7;

   typedef enum logic [CMD_W-1:0] {
      CMD_PACKET    = 3'd0,
      CMD_FRAME     = 3'd1,
      CMD_CKSUM_ERR = 3'd2,
      CMD_TIMEOUT   = 3'd3,
      CMD_OTHER     = 3'd4
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE    = 2'd0,
      KIND_SEND    = 2'd1,
      KIND_DELIVER = 2'd2
   } kind_type;

   // one result item as held in the output register
   typedef struct packed {
      logic                valid;
      logic [KIND_W-1:0]   kind;
      logic [SEQ_W-1:0]    seq;
      logic [SEQ_W-1:0]    ack;
      logic [DATA_W-1:0]   data;
      logic [SEQ_W-1:0]    freed;
      logic                net_en;
      logic                refused;
      logic                last;
      logic                from_buf;   // data comes from the frame buffer read port
   } rsp_type;

   // s + 1 modulo m, with s < m
   function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s,
                                                input logic [MOD_W-1:0] m);
      logic [MOD_W-1:0] sum;
      sum = {1'b0, s} + 4'd1;
      return (sum >= m) ? '0 : sum[SEQ_W-1:0];
   endfunction

   // s - 1 modulo m, with s < m
   function automatic logic [SEQ_W-1:0] seq_dec(input logic [SEQ_W-1:0] s,
                                                input logic [MOD_W-1:0] m);
      logic [MOD_W-1:0] top;
      top = m - 4'd1;
      return (s == '0) ? top[SEQ_W-1:0] : s - 3'd1;
   endfunction

   // (a - b) modulo m, with a, b < m
   function automatic logic [MOD_W-1:0] seq_diff(input logic [SEQ_W-1:0] a,
                                                 input logic [SEQ_W-1:0] b,
                                                 input logic [MOD_W-1:0] m);
      return (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + m - {1'b0, b});
   endfunction

endpackage

### rtl/go_back_n_arq_sender.sv
// Go-Back-N ARQ sender/receiver endpoint: command sequencer and window state.
// Depends on gbn_pkg and gbn_frame_buf.
//
// Usage
//  - Input: one event item per start pulse, taken at an edge where start is
//    high and busy is low. req_command picks the event (packet ready, frame
//    arrival, checksum error, timeout, other).
//  - Results: one or more items, each on the rsp_ ports for exactly one cycle
//    with rsp_valid high; rsp_last marks the final item of an event. The
//    receiver cannot stall, so results are simply strobed out.
//  - Config: csr_wr_en writes the window limit from csr_wr_data and clears the
//    send, ack, receive and outstanding counters; the user must write it only
//    while idle, and the block itself leaves this unchecked.
//  - Timing: packet, frame arrival and no-op events pass the execute state;
//    the result is registered and shows on the ports as busy drops, so the
//    next item is taken at the edge that ends that result. A timeout with N
//    frames outstanding enters the resend state and sends the N frames back
//    to back from the single buffer read port; the first follows the execute
//    state and a buffer read, and busy stays high until the last one shows,
//    so the next accept comes at the edge that ends the last resent frame.
//  - Reset (synchronous, active high) clears the counters and restores the
//    window limit to 7. Buffer contents are not cleared; only written entries
//    are ever read back.

module go_back_n_arq_sender #(
   parameter int SEQ_SPACE = gbn_pkg::SEQ_SPACE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [gbn_pkg::CMD_W-1:0]   req_command,
   input  logic [gbn_pkg::DATA_W-1:0]  req_packet_word,
   input  logic [gbn_pkg::SEQ_W-1:0]   req_frame_seq,
   input  logic [gbn_pkg::SEQ_W-1:0]   req_frame_ack,
   input  logic [gbn_pkg::DATA_W-1:0]  req_frame_payload,
   input  logic                        csr_wr_en,
   input  logic [gbn_pkg::WIN_W-1:0]   csr_wr_data,
   output logic                        rsp_valid,
   output logic [gbn_pkg::KIND_W-1:0]  rsp_result_kind,
   output logic [gbn_pkg::SEQ_W-1:0]   rsp_out_seq,
   output logic [gbn_pkg::SEQ_W-1:0]   rsp_out_ack,
   output logic [gbn_pkg::DATA_W-1:0]  rsp_out_data,
   output logic [gbn_pkg::SEQ_W-1:0]   rsp_freed_count,
   output logic                        rsp_network_enable,
   output logic                        rsp_refused,
   output logic                        rsp_last
);

   localparam int IDX_W = $clog2(SEQ_SPACE);
   // window clamps to SEQ_SPACE-1, and never beyond what 3 bits hold
   localparam int WMAX  = (SEQ_SPACE - 1 > 7) ? 7 : SEQ_SPACE - 1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EXEC   = 3'b010,
      ST_RESEND = 3'b100
   } state_type;

   state_type                     state_ff, state_in;

   logic [gbn_pkg::WIN_W-1:0]     window_ff;
   logic [gbn_pkg::SEQ_W-1:0]     next_send_ff, next_send_in;
   logic [gbn_pkg::SEQ_W-1:0]     oldest_ff, oldest_in;
   logic [gbn_pkg::SEQ_W-1:0]     expected_ff, expected_in;
   logic [gbn_pkg::SEQ_W-1:0]     outstanding_ff, outstanding_in;

   // resend scan: current sequence number and frames still to go
   logic [gbn_pkg::SEQ_W-1:0]     scan_ff, scan_in;
   logic [gbn_pkg::SEQ_W-1:0]     remain_ff, remain_in;

   // latched event item
   logic [gbn_pkg::CMD_W-1:0]     cmd_ff;
   logic [gbn_pkg::DATA_W-1:0]    pkt_ff;
   logic [gbn_pkg::SEQ_W-1:0]     fseq_ff;
   logic [gbn_pkg::SEQ_W-1:0]     fack_ff;
   logic [gbn_pkg::DATA_W-1:0]    fpay_ff;

   gbn_pkg::rsp_type              rsp_ff, rsp_in;

   logic [gbn_pkg::WIN_W-1:0]     win_eff;
   logic [gbn_pkg::MOD_W-1:0]     modulus;
   logic [gbn_pkg::SEQ_W-1:0]     pack;
   logic [gbn_pkg::MOD_W-1:0]     ack_dist;
   logic                          accept;
   logic                          buf_wr_en;
   logic                          buf_rd_en;
   logic [gbn_pkg::DATA_W-1:0]    buf_rd_data;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // effective window: 0 acts as 1, clamp to the sequence space
   always_comb begin
      if (window_ff == '0) begin
         win_eff = 3'd1;
      end else if (window_ff > 3'(WMAX)) begin
         win_eff = 3'(WMAX);
      end else begin
         win_eff = window_ff;
      end
   end

   assign modulus  = {1'b0, win_eff} + 4'd1;
   // piggybacked ack: last in-order frame received
   assign pack     = gbn_pkg::seq_dec(expected_ff, modulus);
   // circular distance of the incoming ack from the oldest unacked frame
   assign ack_dist = gbn_pkg::seq_diff(fack_ff, oldest_ff, modulus);

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      next_send_in   = next_send_ff;
      oldest_in      = oldest_ff;
      expected_in    = expected_ff;
      outstanding_in = outstanding_ff;
      scan_in        = scan_ff;
      remain_in      = remain_ff;
      buf_wr_en      = 1'b0;
      buf_rd_en      = 1'b0;
      rsp_in         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_in.valid = 1'b1;
            rsp_in.last  = 1'b1;
            case (cmd_ff)
               gbn_pkg::CMD_PACKET: begin
                  if (outstanding_ff >= win_eff) begin
                     // window full: drop and flag
                     rsp_in.refused = 1'b1;
                  end else begin
                     buf_wr_en      = 1'b1;
                     rsp_in.kind    = gbn_pkg::KIND_SEND;
                     rsp_in.seq     = next_send_ff;
                     rsp_in.ack     = pack;
                     rsp_in.data    = pkt_ff;
                     outstanding_in = outstanding_ff + 3'd1;
                     next_send_in   = gbn_pkg::seq_inc(next_send_ff, modulus);
                  end
               end

               gbn_pkg::CMD_FRAME: begin
                  if (fseq_ff == expected_ff) begin
                     rsp_in.kind = gbn_pkg::KIND_DELIVER;
                     rsp_in.data = fpay_ff;
                     expected_in = gbn_pkg::seq_inc(expected_ff, modulus);
                  end
                  // ack must lie inside [oldest, next_send) circularly
                  if (({1'b0, fack_ff} < modulus) &&
                      (ack_dist < {1'b0, outstanding_ff})) begin
                     rsp_in.freed   = ack_dist[gbn_pkg::SEQ_W-1:0] + 3'd1;
                     outstanding_in = outstanding_ff - ack_dist[gbn_pkg::SEQ_W-1:0]
                                      - 3'd1;
                     oldest_in      = gbn_pkg::seq_inc(fack_ff, modulus);
                  end
               end

               gbn_pkg::CMD_TIMEOUT: begin
                  if (outstanding_ff != '0) begin
                     rsp_in.valid = 1'b0;
                     rsp_in.last  = 1'b0;
                     state_in     = ST_RESEND;
                     scan_in      = oldest_ff;
                     remain_in    = outstanding_ff;
                  end
               end

               default: begin
                  // checksum error, other and unknown commands: no action
               end
            endcase
            rsp_in.net_en = (outstanding_in < win_eff);
         end

         ST_RESEND: begin
            // one buffer read per cycle; data lines up with rsp_ff next cycle
            buf_rd_en       = 1'b1;
            rsp_in.valid    = 1'b1;
            rsp_in.kind     = gbn_pkg::KIND_SEND;
            rsp_in.seq      = scan_ff;
            rsp_in.ack      = pack;
            rsp_in.from_buf = 1'b1;
            rsp_in.net_en   = (outstanding_ff < win_eff);
            scan_in         = gbn_pkg::seq_inc(scan_ff, modulus);
            remain_in       = remain_ff - 3'd1;
            if (remain_ff == 3'd1) begin
               rsp_in.last  = 1'b1;
               state_in     = ST_IDLE;
               next_send_in = gbn_pkg::seq_inc(scan_ff, modulus);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         window_ff      <= gbn_pkg::WINDOW_RESET;
         next_send_ff   <= '0;
         oldest_ff      <= '0;
         expected_ff    <= '0;
         outstanding_ff <= '0;
         scan_ff        <= '0;
         remain_ff      <= '0;
         rsp_ff         <= '0;
      end else begin
         state_ff  <= state_in;
         scan_ff   <= scan_in;
         remain_ff <= remain_in;
         rsp_ff    <= rsp_in;
         if (csr_wr_en) begin
            // new modulus: restart all sequence state, keep the buffer
            window_ff      <= csr_wr_data;
            next_send_ff   <= '0;
            oldest_ff      <= '0;
            expected_ff    <= '0;
            outstanding_ff <= '0;
         end else begin
            next_send_ff   <= next_send_in;
            oldest_ff      <= oldest_in;
            expected_ff    <= expected_in;
            outstanding_ff <= outstanding_in;
         end
      end
   end

   // event item capture
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         pkt_ff  <= req_packet_word;
         fseq_ff <= req_frame_seq;
         fack_ff <= req_frame_ack;
         fpay_ff <= req_frame_payload;
      end
   end

   gbn_frame_buf #(
      .DEPTH (SEQ_SPACE)
   ) u_frame_buf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (IDX_W'(next_send_ff)),
      .wr_data (pkt_ff),
      .rd_en   (buf_rd_en),
      .rd_addr (IDX_W'(scan_ff)),
      .rd_data (buf_rd_data)
   );

   assign rsp_valid          = rsp_ff.valid;
   assign rsp_result_kind    = rsp_ff.kind;
   assign rsp_out_seq        = rsp_ff.seq;
   assign rsp_out_ack        = rsp_ff.ack;
   assign rsp_out_data       = rsp_ff.from_buf ? buf_rd_data : rsp_ff.data;
   assign rsp_freed_count    = rsp_ff.freed;
   assign rsp_network_enable = rsp_ff.net_en;
   assign rsp_refused        = rsp_ff.refused;
   assign rsp_last           = rsp_ff.last;

`ifndef SYNTH
   // a result only follows a cycle of work
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobed without preceding work");

   // the final result of an item finds the sequencer idle again
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("final result while sequencer still busy");

   // never more frames outstanding than the window allows
   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= win_eff)
      else $error("outstanding count exceeds window");
`endif

endmodule

### rtl/gbn_frame_buf.sv
// Retransmit buffer: one write port, one registered read port.
// Depends on gbn_pkg for the data width and the default depth.

module gbn_frame_buf #(
   parameter int DEPTH = gbn_pkg::SEQ_SPACE_DEF
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [gbn_pkg::DATA_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [gbn_pkg::DATA_W-1:0] rd_data
);

   logic [gbn_pkg::DATA_W-1:0] mem_ff [DEPTH];
   logic [gbn_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/gbn_result_checker.sv
// Result checker for the Go-Back-N sender: tracks window state from accepted items and
// window writes, predicts each result item and compares the strobed results in order.
// Depends on gbn_pkg.
`timescale 1ns / 1ps

module gbn_result_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [gbn_pkg::CMD_W-1:0]   req_command,
   input  logic [gbn_pkg::DATA_W-1:0]  req_packet_word,
   input  logic [gbn_pkg::SEQ_W-1:0]   req_frame_seq,
   input  logic [gbn_pkg::SEQ_W-1:0]   req_frame_ack,
   input  logic [gbn_pkg::DATA_W-1:0]  req_frame_payload,
   input  logic                        csr_wr_en,
   input  logic [gbn_pkg::WIN_W-1:0]   csr_wr_data,
   input  logic                        rsp_valid,
   input  logic [gbn_pkg::KIND_W-1:0]  rsp_result_kind,
   input  logic [gbn_pkg::SEQ_W-1:0]   rsp_out_seq,
   input  logic [gbn_pkg::SEQ_W-1:0]   rsp_out_ack,
   input  logic [gbn_pkg::DATA_W-1:0]  rsp_out_data,
   input  logic [gbn_pkg::SEQ_W-1:0]   rsp_freed_count,
   input  logic                        rsp_network_enable,
   input  logic                        rsp_refused,
   input  logic                        rsp_last,
   output int                          mismatches,
   output int                          awaiting,
   output int                          compared
);

   typedef struct packed {
      gbn_pkg::kind_type            kind;
      logic [gbn_pkg::SEQ_W-1:0]    seq;
      logic [gbn_pkg::SEQ_W-1:0]    ack;
      logic [gbn_pkg::DATA_W-1:0]   data;
      logic [gbn_pkg::SEQ_W-1:0]    freed;
      logic                         net_en;
      logic                         refused;
      logic                         last;
   } link_result_type;

   link_result_type              awaited_results[$];
   logic [gbn_pkg::WIN_W-1:0]    win_reg;
   logic [gbn_pkg::SEQ_W-1:0]    nxt_seq;
   logic [gbn_pkg::SEQ_W-1:0]    base_seq;
   logic [gbn_pkg::SEQ_W-1:0]    rx_seq;
   int                           in_flight;
   logic [gbn_pkg::DATA_W-1:0]   resend_buf [gbn_pkg::SEQ_SPACE_DEF];
   int                           err_cnt = 0;
   int                           cmp_cnt = 0;

   function automatic link_result_type make_result(input gbn_pkg::kind_type kind,
                                                   input int seq, input int ack,
                                                   input logic [gbn_pkg::DATA_W-1:0] data,
                                                   input int freed, input logic refused);
      link_result_type r;
      r.kind    = kind;
      r.seq     = gbn_pkg::SEQ_W'(seq);
      r.ack     = gbn_pkg::SEQ_W'(ack);
      r.data    = data;
      r.freed   = gbn_pkg::SEQ_W'(freed);
      r.net_en  = 1'b0;
      r.refused = refused;
      r.last    = 1'b0;
      return r;
   endfunction

   function automatic string show(input link_result_type r);
      return $sformatf("kind=%0d seq=%0d ack=%0d data=%h freed=%0d net_en=%b refused=%b last=%b",
                       r.kind, r.seq, r.ack, r.data, r.freed, r.net_en, r.refused, r.last);
   endfunction

   // advance the window state by one event and queue the results it produces
   task automatic predict_event(input logic [gbn_pkg::CMD_W-1:0] cmd,
                                input logic [gbn_pkg::DATA_W-1:0] pkt,
                                input logic [gbn_pkg::SEQ_W-1:0] fseq,
                                input logic [gbn_pkg::SEQ_W-1:0] fack,
                                input logic [gbn_pkg::DATA_W-1:0] fpay);
      link_result_type batch [8];
      int           n;
      int           win;
      int           m;
      int           ack_out;
      int           s;
      int           d;
      int           freed;
      int           i;
      logic         delivered;
      n         = 0;
      freed     = 0;
      delivered = 1'b0;
      win       = (win_reg == '0) ? 1 : int'(win_reg);
      m         = win + 1;
      ack_out   = (int'(rx_seq) + m - 1) % m;
      if (cmd == gbn_pkg::CMD_PACKET) begin
         if (in_flight >= win) begin
            batch[n++] = make_result(gbn_pkg::KIND_NONE, 0, 0, '0, 0, 1'b1);
         end else begin
            s = int'(nxt_seq) % m;
            resend_buf[s] = pkt;
            in_flight++;
            batch[n++] = make_result(gbn_pkg::KIND_SEND, s, ack_out, pkt, 0, 1'b0);
            nxt_seq = gbn_pkg::SEQ_W'((s + 1) % m);
         end
      end else if (cmd == gbn_pkg::CMD_FRAME) begin
         if (fseq == rx_seq) begin
            delivered = 1'b1;
            rx_seq    = gbn_pkg::SEQ_W'((int'(rx_seq) + 1) % m);
         end
         // acks outside [base, next) circularly, or beyond the modulus, free nothing
         if (int'(fack) < m) begin
            d = (int'(fack) + m - int'(base_seq)) % m;
            if (d < in_flight) begin
               freed     = d + 1;
               in_flight = in_flight - freed;
               base_seq  = gbn_pkg::SEQ_W'((int'(fack) + 1) % m);
            end
         end
         if (delivered)
            batch[n++] = make_result(gbn_pkg::KIND_DELIVER, 0, 0, fpay, freed, 1'b0);
         else
            batch[n++] = make_result(gbn_pkg::KIND_NONE, 0, 0, '0, freed, 1'b0);
      end else if (cmd == gbn_pkg::CMD_TIMEOUT && in_flight > 0) begin
         s = int'(base_seq) % m;
         for (i = 0; i < in_flight && i < 7; i++) begin
            batch[n++] = make_result(gbn_pkg::KIND_SEND, s, ack_out, resend_buf[s], 0,
                                     1'b0);
            s = (s + 1) % m;
         end
         nxt_seq = gbn_pkg::SEQ_W'(s);
      end else begin
         batch[n++] = make_result(gbn_pkg::KIND_NONE, 0, 0, '0, 0, 1'b0);
      end
      for (i = 0; i < n; i++) begin
         batch[i].net_en = (in_flight < win);
         batch[i].last   = (i == n - 1);
         awaited_results.push_back(batch[i]);
      end
   endtask

   always @(posedge clock) begin
      link_result_type act;
      link_result_type exp_r;
      if (reset) begin
         awaited_results.delete();
         win_reg   = gbn_pkg::WINDOW_RESET;
         nxt_seq   = '0;
         base_seq  = '0;
         rx_seq    = '0;
         in_flight = 0;
      end else begin
         if (rsp_valid) begin
            act = make_result(gbn_pkg::kind_type'(rsp_result_kind), int'(rsp_out_seq),
                              int'(rsp_out_ack), rsp_out_data, int'(rsp_freed_count),
                              rsp_refused);
            act.net_en = rsp_network_enable;
            act.last   = rsp_last;
            if (awaited_results.size() == 0) begin
               err_cnt++;
               if (err_cnt <= 10)
                  $display("%t: unexpected result item %s", $realtime, show(act));
            end else begin
               exp_r = awaited_results.pop_front();
               cmp_cnt++;
               if (exp_r != act) begin
                  err_cnt++;
                  if (err_cnt <= 10) begin
                     $display("%t: result mismatch", $realtime);
                     $display("   expected %s", show(exp_r));
                     $display("   actual   %s", show(act));
                  end
               end
            end
         end
         // window write restarts all sequence counters, buffer contents survive
         if (csr_wr_en) begin
            win_reg   = csr_wr_data;
            nxt_seq   = '0;
            base_seq  = '0;
            rx_seq    = '0;
            in_flight = 0;
         end
         if (start && !busy)
            predict_event(req_command, req_packet_word, req_frame_seq, req_frame_ack,
                          req_frame_payload);
      end
      mismatches <= err_cnt;
      awaiting   <= awaited_results.size();
      compared   <= cmp_cnt;
   end

endmodule

### tb/testbench.sv
// Top level for the Go-Back-N sender test: clock, reset, item and window-write stimulus,
// final verdict. Depends on gbn_pkg, go_back_n_arq_sender and gbn_result_checker.
`timescale 1ns / 1ps

module testbench;

   // commands past CMD_OTHER have no name in the package but must be harmless
   localparam logic [gbn_pkg::CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
   localparam logic [gbn_pkg::CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int ITEMS_PER_PHASE = 19;
   localparam int PHASES          = 8;

   // window settings per random phase, phase 0 in the low bits: 1,0,3,7,2,5,4,6
   localparam logic [PHASES*gbn_pkg::WIN_W-1:0] WINDOW_PLAN =
      {3'd6, 3'd4, 3'd5, 3'd2, 3'd7, 3'd3, 3'd0, 3'd1};

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [gbn_pkg::CMD_W-1:0]    req_command = '0;
   logic [gbn_pkg::DATA_W-1:0]   req_packet_word = '0;
   logic [gbn_pkg::SEQ_W-1:0]    req_frame_seq = '0;
   logic [gbn_pkg::SEQ_W-1:0]    req_frame_ack = '0;
   logic [gbn_pkg::DATA_W-1:0]   req_frame_payload = '0;
   logic                         csr_wr_en = 1'b0;
   logic [gbn_pkg::WIN_W-1:0]    csr_wr_data = '0;
   logic                         rsp_valid;
   logic [gbn_pkg::KIND_W-1:0]   rsp_result_kind;
   logic [gbn_pkg::SEQ_W-1:0]    rsp_out_seq;
   logic [gbn_pkg::SEQ_W-1:0]    rsp_out_ack;
   logic [gbn_pkg::DATA_W-1:0]   rsp_out_data;
   logic [gbn_pkg::SEQ_W-1:0]    rsp_freed_count;
   logic                         rsp_network_enable;
   logic                         rsp_refused;
   logic                         rsp_last;

   int                           mismatches;
   int                           awaiting;
   int                           compared;
   int                           cycles = 0;
   int                           items_sent = 0;
   int                           windows_used = 1;   // the reset value counts as one setting
   logic [gbn_pkg::SEQ_W-1:0]    last_sent = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   go_back_n_arq_sender u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_packet_word    (req_packet_word),
      .req_frame_seq      (req_frame_seq),
      .req_frame_ack      (req_frame_ack),
      .req_frame_payload  (req_frame_payload),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_out_seq        (rsp_out_seq),
      .rsp_out_ack        (rsp_out_ack),
      .rsp_out_data       (rsp_out_data),
      .rsp_freed_count    (rsp_freed_count),
      .rsp_network_enable (rsp_network_enable),
      .rsp_refused        (rsp_refused),
      .rsp_last           (rsp_last)
   );

   gbn_result_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_packet_word    (req_packet_word),
      .req_frame_seq      (req_frame_seq),
      .req_frame_ack      (req_frame_ack),
      .req_frame_payload  (req_frame_payload),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_out_seq        (rsp_out_seq),
      .rsp_out_ack        (rsp_out_ack),
      .rsp_out_data       (rsp_out_data),
      .rsp_freed_count    (rsp_freed_count),
      .rsp_network_enable (rsp_network_enable),
      .rsp_refused        (rsp_refused),
      .rsp_last           (rsp_last),
      .mismatches         (mismatches),
      .awaiting           (awaiting),
      .compared           (compared)
   );

   // watchdog: a hung handshake or a missing result ends the run here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles, %0d results still due", cycles, awaiting);
         $display("tb: failure");
         $finish;
      end
   end

   // Remember the newest frame the block put on the wire, so random arrivals can carry
   // acks that land inside the send window. A window write restarts numbering.
   always @(posedge clock) begin
      if (csr_wr_en)
         last_sent <= '0;
      else if (rsp_valid && rsp_result_kind == gbn_pkg::KIND_SEND)
         last_sent <= rsp_out_seq;
   end

   // Present one item and hold it until the block takes it. Returns in the time step of
   // the accepting edge with start still high, so a following item can go out back to
   // back without start dropping.
   task automatic issue(input logic [gbn_pkg::CMD_W-1:0] cmd,
                        input logic [gbn_pkg::DATA_W-1:0] pkt,
                        input logic [gbn_pkg::SEQ_W-1:0] fseq,
                        input logic [gbn_pkg::SEQ_W-1:0] fack,
                        input logic [gbn_pkg::DATA_W-1:0] fpay);
      req_command       <= cmd;
      req_packet_word   <= pkt;
      req_frame_seq     <= fseq;
      req_frame_ack     <= fack;
      req_frame_payload <= fpay;
      start             <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // Drop start and wait until every predicted result has been seen and the block is
   // idle, plus a short hold-off. The first edge lets the checker count the last item.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (awaiting != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window(input logic [gbn_pkg::WIN_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      windows_used++;
   endtask

   // mostly back to back or short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   initial begin
      int                           p;
      int                           k;
      int                           gap;
      int                           sel;
      int                           win_eff;
      int                           mod;
      int                           rx_next;
      int                           back;
      bit                           no_gaps;
      logic [gbn_pkg::CMD_W-1:0]    cmd;
      logic [gbn_pkg::CMD_W-1:0]    odd_cmd;
      logic [gbn_pkg::DATA_W-1:0]   pkt;
      logic [gbn_pkg::DATA_W-1:0]   fpay;
      logic [gbn_pkg::SEQ_W-1:0]    fseq;
      logic [gbn_pkg::SEQ_W-1:0]    fack;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part, reset window of 7 ----
      // Fill the window: seq 0..6, data extremes on the first two.
      issue(gbn_pkg::CMD_PACKET, 32'h0000_0000, '0, '0, '0);
      issue(gbn_pkg::CMD_PACKET, 32'hFFFF_FFFF, '0, '0, '0);
      for (k = 0; k < 5; k++)
         issue(gbn_pkg::CMD_PACKET, $urandom(), '0, '0, '0);
      // window now full: refused
      issue(gbn_pkg::CMD_PACKET, 32'h5A5A_A5A5, '0, '0, '0);
      // timeout with a full window: seven resends, the longest burst
      issue(gbn_pkg::CMD_TIMEOUT, '0, '0, '0, '0);
      // in-order frame, ack covers three of the seven
      issue(gbn_pkg::CMD_FRAME, '0, 3'd0, 3'd2, 32'hFFFF_FFFF);
      // out-of-sequence frame with an ack behind the window: no delivery, nothing freed
      issue(gbn_pkg::CMD_FRAME, '0, 3'd5, 3'd1, 32'h0000_0000);
      // events that do nothing, unknown commands included
      issue(gbn_pkg::CMD_CKSUM_ERR, 32'hFFFF_FFFF, 3'd7, 3'd7, 32'hFFFF_FFFF);
      issue(gbn_pkg::CMD_OTHER, '0, '0, '0, '0);
      for (odd_cmd = CMD_UNKNOWN_LO; odd_cmd != CMD_UNKNOWN_HI; odd_cmd++)
         issue(odd_cmd, $urandom(), '0, '0, $urandom());
      issue(CMD_UNKNOWN_HI, $urandom(), '0, '0, $urandom());
      // in-order frame acking the rest, then a timeout with nothing outstanding
      issue(gbn_pkg::CMD_FRAME, '0, 3'd1, 3'd6, $urandom());
      issue(gbn_pkg::CMD_TIMEOUT, '0, '0, '0, '0);

      // ---- directed part, window of 2 (modulus 3) ----
      settle();
      write_window(3'd2);
      issue(gbn_pkg::CMD_PACKET, $urandom(), '0, '0, '0);
      // ack beyond the modulus is ignored, the frame itself is still delivered
      issue(gbn_pkg::CMD_FRAME, '0, 3'd0, 3'd7, $urandom());
      // frame seq beyond the modulus is never in order, ack 0 frees the one frame
      issue(gbn_pkg::CMD_FRAME, '0, 3'd7, 3'd0, $urandom());

      // ---- random phases, one window setting each ----
      for (p = 0; p < PHASES; p++) begin
         settle();
         write_window(WINDOW_PLAN[p*gbn_pkg::WIN_W +: gbn_pkg::WIN_W]);
         win_eff = (WINDOW_PLAN[p*gbn_pkg::WIN_W +: gbn_pkg::WIN_W] == '0) ? 1 :
                   int'(WINDOW_PLAN[p*gbn_pkg::WIN_W +: gbn_pkg::WIN_W]);
         mod     = win_eff + 1;
         rx_next = 0;
         // some phases run without the random gaps
         no_gaps = ($urandom_range(0, 2) == 0);
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (!no_gaps) begin
               gap = pick_gap();
               if (gap > 0) begin
                  start <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
            // occasionally let the block drain completely before the next item
            if ($urandom_range(0, 24) == 0)
               settle();

            sel  = $urandom_range(0, 99);
            pkt  = $urandom();
            fpay = $urandom();
            fseq = gbn_pkg::SEQ_W'($urandom_range(0, 7));
            fack = gbn_pkg::SEQ_W'($urandom_range(0, 7));
            if (sel < 40) begin
               cmd = gbn_pkg::CMD_PACKET;
            end else if (sel < 75) begin
               // mostly a well-behaved peer: in-order frames, acks at or just behind
               // the newest frame sent; the rest is noise
               cmd = gbn_pkg::CMD_FRAME;
               if ($urandom_range(0, 3) != 0)
                  fseq = gbn_pkg::SEQ_W'(rx_next);
               if ($urandom_range(0, 9) < 7) begin
                  back = $urandom_range(0, 2);
                  fack = gbn_pkg::SEQ_W'((int'(last_sent) + 2 * mod - back) % mod);
               end
            end else if (sel < 85) begin
               cmd = gbn_pkg::CMD_TIMEOUT;
            end else if (sel < 92) begin
               cmd = gbn_pkg::CMD_CKSUM_ERR;
            end else if (sel < 96) begin
               cmd = gbn_pkg::CMD_OTHER;
            end else begin
               cmd = gbn_pkg::CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
            end
            issue(cmd, pkt, fseq, fack, fpay);
            if (cmd == gbn_pkg::CMD_FRAME && int'(fseq) == rx_next)
               rx_next = (rx_next + 1) % mod;
         end
      end

      // drain, then a tail to catch any stray result
      settle();
      repeat (20) @(posedge clock);

      $display("tb: covered %0d items under %0d window settings", items_sent, windows_used);
      $display("tb: %0d result items compared, %0d mismatches", compared, mismatches);
      if (mismatches == 0 && awaiting == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### sim.f
rtl/gbn_pkg.sv
rtl/gbn_frame_buf.sv
rtl/go_back_n_arq_sender.sv
tb/gbn_result_checker.sv
tb/testbench.sv
